// ===== design/gbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types and constants for the gshare predictor with target buffer:
// transaction payloads, configuration register codes and reset values.
// ----------------------------------------------------------------------------
package gbp_pkg;

    // default sizes handed to the top level
    localparam int PATTERN_INDEX_BITS_DEF = 10;
    localparam int BTB_DEPTH_DEF          = 64;

    // global history register
    localparam int HIST_MAX_BITS = 10;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HISTORY_BITS   = 2'd0,
        CFG_BTB_INDEX_BITS = 2'd1
    } t_cfg_reg;

    localparam logic [3:0] HISTORY_BITS_RESET   = 4'd4;
    localparam logic [2:0] BTB_INDEX_BITS_RESET = 3'd6;

    // 2-bit counter values
    localparam logic [1:0] CNT_STRONG_TAKEN     = 2'd3;
    localparam logic [1:0] CNT_STRONG_NOT_TAKEN = 2'd0;

    // fall-through distance
    localparam logic [63:0] INSN_BYTES = 64'd4;

    // power-up sequencing
    typedef enum logic {
        INIT_CLEAR,
        INIT_RUN
    } t_init_state;

    // resolved branch transaction
    typedef struct packed {
        logic [63:0] branch_pc;
        logic        taken;
        logic [63:0] actual_target;
    } t_in_item;

    // prediction report transaction
    typedef struct packed {
        logic        predicted_taken;
        logic [63:0] predicted_target;
        logic        direction_correct;
        logic        target_correct;
        logic [31:0] branch_count;
        logic [31:0] direction_hits;
        logic [31:0] target_hits;
    } t_out_item;

endpackage

// ===== design/gshare_branch_predictor_btb.sv =====
// ----------------------------------------------------------------------------
// gshare_branch_predictor_btb
// gshare direction predictor with a direct-mapped branch target buffer,
// reporting prediction, correctness and running hit totals per branch.
// ----------------------------------------------------------------------------
// Usage: one resolved branch is accepted every cycle unless the output
// stalls or the clearing pass runs; its report passes through the stage 1
// registers and then an output register, so a report can wait while the
// next branch is taken in. The pattern counters and the target buffer live
// in synchronous RAMs; each branch reads its counter and buffer entry at
// acceptance and writes them back when it leaves stage 1, and a branch
// that reads the entry being written by the one before it gets the new
// value forwarded. After reset a clearing pass sets every counter to
// strongly taken and every buffer entry to zero; input stays stalled for
// its duration while configuration writes are taken as usual.
// Configuration must be written only while no branch is in flight.
module gshare_branch_predictor_btb #(
    parameter int PATTERN_INDEX_BITS = gbp_pkg::PATTERN_INDEX_BITS_DEF,
    parameter int BTB_DEPTH          = gbp_pkg::BTB_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // branch input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  gbp_pkg::t_in_item                  i_in_data,
    // report output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output gbp_pkg::t_out_item                 o_out_data,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [gbp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [gbp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import gbp_pkg::*;

    localparam int PAW         = PATTERN_INDEX_BITS;
    localparam int PAT_ENTRIES = 1 << PAW;
    localparam int BTB_AW      = (BTB_DEPTH > 1) ? $clog2(BTB_DEPTH) : 1;
    localparam int CLR_DEPTH   = (PAT_ENTRIES > BTB_DEPTH) ? PAT_ENTRIES : BTB_DEPTH;
    localparam int CLR_W       = $clog2(CLR_DEPTH) + 1;

    // buffer index reduced modulo the depth, one conditional subtract per bit
    function automatic logic [BTB_AW-1:0] btb_reduce(input logic [6:0] v);
        logic [17:0] r;
        r = {11'd0, v};
        for (int k = 6; k >= 0; k--) begin
            if (r >= (18'(BTB_DEPTH) << k)) begin
                r = r - (18'(BTB_DEPTH) << k);
            end
        end
        return r[BTB_AW-1:0];
    endfunction

    // configuration and history
    logic [3:0]             r_history_bits;
    logic [2:0]             r_btb_index_bits;
    logic [HIST_MAX_BITS-1:0] r_history;

    // power-up clearing pass
    t_init_state            r_init_state, n_init_state;
    logic [CLR_W-1:0]       r_clr_idx;
    logic                   clr_active;

    // stage 1: memory data valid, update computed
    logic                   r_s1_valid;
    logic [63:0]            r_s1_pc;
    logic                   r_s1_taken;
    logic [63:0]            r_s1_act;
    logic [PAW-1:0]         r_s1_pi;
    logic [BTB_AW-1:0]      r_s1_bi;
    logic                   r_fwd_pat_hit;
    logic [1:0]             r_fwd_pat_val;
    logic                   r_fwd_btb_hit;
    logic [63:0]            r_fwd_btb_val;

    // totals and output register
    logic [31:0]            r_branch_total, n_branch_total;
    logic [31:0]            r_dir_total, n_dir_total;
    logic [31:0]            r_tgt_total, n_tgt_total;
    logic                   r_out_valid;
    t_out_item              r_out_data, n_out_data;

    // handshake
    logic                   in_accept;
    logic                   s1_fire;

    // index computation
    logic [3:0]             hist_len;
    logic [HIST_MAX_BITS:0] hm_wide;
    logic [HIST_MAX_BITS-1:0] hm;
    logic [HIST_MAX_BITS-1:0] hist_masked;
    logic [PAW-1:0]         hist_ext;
    logic [PAW-1:0]         pi_new;
    logic [7:0]             bsel_mask;
    logic [BTB_AW-1:0]      bi_new;

    // stage 1 datapath
    logic [1:0]             pat_rdata;
    logic [63:0]            btb_rdata;
    logic [1:0]             cnt_cur;
    logic [1:0]             cnt_new;
    logic [63:0]            btb_cur;
    logic                   ptk;
    logic [63:0]            fall;
    logic [63:0]            ptgt;
    logic                   dok;
    logic                   tok;

    // memory ports
    logic                   pat_we;
    logic [PAW-1:0]         pat_waddr;
    logic [1:0]             pat_wdata;
    logic                   btb_we;
    logic [BTB_AW-1:0]      btb_waddr;
    logic [63:0]            btb_wdata;

    // handshake control
    assign s1_fire    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = clr_active || (r_s1_valid && !s1_fire);
    assign in_accept  = i_in_valid && !o_in_stall;

    // history mask, length capped at the register width
    always_comb begin
        hist_len    = (r_history_bits > 4'(HIST_MAX_BITS)) ? 4'(HIST_MAX_BITS)
                                                            : r_history_bits;
        hm_wide     = ((HIST_MAX_BITS + 1)'(1) << hist_len) - (HIST_MAX_BITS + 1)'(1);
        hm          = hm_wide[HIST_MAX_BITS-1:0];
        hist_masked = r_history & hm;
    end

    // pattern index: word address xor history, fitted to the table width
    always_comb begin
        for (int k = 0; k < PAW; k++) begin
            hist_ext[k] = (k < HIST_MAX_BITS) ? hist_masked[k % HIST_MAX_BITS] : 1'b0;
        end
        pi_new = i_in_data.branch_pc[2 +: PAW] ^ hist_ext;
    end

    // buffer index from the low word address bits in use
    always_comb begin
        bsel_mask = (8'd1 << r_btb_index_bits) - 8'd1;
        bi_new    = btb_reduce(i_in_data.branch_pc[8:2] & bsel_mask[6:0]);
    end

    // configuration registers and global history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_history_bits   <= HISTORY_BITS_RESET;
            r_btb_index_bits <= BTB_INDEX_BITS_RESET;
            r_history        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HISTORY_BITS:   r_history_bits   <= i_cfg_data[3:0];
                    CFG_BTB_INDEX_BITS: r_btb_index_bits <= i_cfg_data[2:0];
                    default:            ;
                endcase
            end
            if (in_accept) begin
                r_history <= {r_history[HIST_MAX_BITS-2:0], i_in_data.taken} & hm;
            end
        end
    end

    // clearing pass: next state
    always_comb begin
        n_init_state = r_init_state;
        unique case (r_init_state)
            INIT_CLEAR: begin
                if (r_clr_idx == CLR_W'(CLR_DEPTH - 1)) begin
                    n_init_state = INIT_RUN;
                end
            end
            INIT_RUN:   n_init_state = INIT_RUN;
            default:    n_init_state = INIT_CLEAR;
        endcase
    end

    // clearing pass: outputs
    always_comb begin
        unique case (r_init_state)
            INIT_CLEAR: clr_active = 1'b1;
            INIT_RUN:   clr_active = 1'b0;
            default:    clr_active = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_state <= INIT_CLEAR;
            r_clr_idx    <= '0;
        end else begin
            r_init_state <= n_init_state;
            if (clr_active) begin
                r_clr_idx <= r_clr_idx + CLR_W'(1);
            end
        end
    end

    // stage 1 registers and forwarding from the write-back at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pc       <= i_in_data.branch_pc;
            r_s1_taken    <= i_in_data.taken;
            r_s1_act      <= i_in_data.actual_target;
            r_s1_pi       <= pi_new;
            r_s1_bi       <= bi_new;
            r_fwd_pat_hit <= s1_fire && (r_s1_pi == pi_new);
            r_fwd_pat_val <= cnt_new;
            r_fwd_btb_hit <= s1_fire && r_s1_taken && (r_s1_bi == bi_new);
            r_fwd_btb_val <= r_s1_act;
        end
    end

    // prediction and counter update
    always_comb begin
        cnt_cur = r_fwd_pat_hit ? r_fwd_pat_val : pat_rdata;
        btb_cur = r_fwd_btb_hit ? r_fwd_btb_val : btb_rdata;
        ptk     = cnt_cur[1];
        fall    = r_s1_pc + INSN_BYTES;
        ptgt    = ptk ? btb_cur : fall;
        dok     = (ptk == r_s1_taken);
        tok     = r_s1_taken ? (ptgt == r_s1_act) : (ptgt == fall);
        if (r_s1_taken) begin
            cnt_new = (cnt_cur == CNT_STRONG_TAKEN) ? cnt_cur : cnt_cur + 2'd1;
        end else begin
            cnt_new = (cnt_cur == CNT_STRONG_NOT_TAKEN) ? cnt_cur : cnt_cur - 2'd1;
        end
    end

    // saturating totals and report
    always_comb begin
        n_branch_total = (r_branch_total == '1) ? r_branch_total : r_branch_total + 32'd1;
        n_dir_total    = r_dir_total;
        n_tgt_total    = r_tgt_total;
        if (dok && (r_dir_total != '1)) begin
            n_dir_total = r_dir_total + 32'd1;
        end
        if (tok && (r_tgt_total != '1)) begin
            n_tgt_total = r_tgt_total + 32'd1;
        end
        n_out_data.predicted_taken   = ptk;
        n_out_data.predicted_target  = ptgt;
        n_out_data.direction_correct = dok;
        n_out_data.target_correct    = tok;
        n_out_data.branch_count      = n_branch_total;
        n_out_data.direction_hits    = n_dir_total;
        n_out_data.target_hits       = n_tgt_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_branch_total <= '0;
            r_dir_total    <= '0;
            r_tgt_total    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_branch_total <= n_branch_total;
                r_dir_total    <= n_dir_total;
                r_tgt_total    <= n_tgt_total;
                r_out_valid    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // memory write ports: clearing pass or write-back
    always_comb begin
        if (clr_active) begin
            pat_we    = (r_clr_idx < CLR_W'(PAT_ENTRIES));
            pat_waddr = r_clr_idx[PAW-1:0];
            pat_wdata = CNT_STRONG_TAKEN;
            btb_we    = (r_clr_idx < CLR_W'(BTB_DEPTH));
            btb_waddr = r_clr_idx[BTB_AW-1:0];
            btb_wdata = '0;
        end else begin
            pat_we    = s1_fire;
            pat_waddr = r_s1_pi;
            pat_wdata = cnt_new;
            btb_we    = s1_fire && r_s1_taken;
            btb_waddr = r_s1_bi;
            btb_wdata = r_s1_act;
        end
    end

    // pattern counter table
    gbp_ram #(
        .DEPTH (PAT_ENTRIES),
        .WIDTH (2),
        .AW    (PAW)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_re    (in_accept),
        .i_raddr (pi_new),
        .o_rdata (pat_rdata),
        .i_we    (pat_we),
        .i_waddr (pat_waddr),
        .i_wdata (pat_wdata)
    );

    // branch target buffer
    gbp_ram #(
        .DEPTH (BTB_DEPTH),
        .WIDTH (64),
        .AW    (BTB_AW)
    ) u_btb_ram (
        .i_clk   (i_clk),
        .i_re    (in_accept),
        .i_raddr (bi_new),
        .o_rdata (btb_rdata),
        .i_we    (btb_we),
        .i_waddr (btb_waddr),
        .i_wdata (btb_wdata)
    );

endmodule

// ===== design/gbp_ram.sv =====
// ----------------------------------------------------------------------------
// gbp_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read data output and read enable. Read during write of the
// same address returns the old contents.
// ----------------------------------------------------------------------------
module gbp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/tb_gshare_branch_predictor_btb.sv =====
// ----------------------------------------------------------------------------
// tb_gshare_branch_predictor_btb
// Self-checking bench for the gshare predictor with branch target buffer.
// A clocked driver feeds resolved branches from a queue, a built-in
// predictor tracks counters, history, target buffer and hit totals, and a
// clocked monitor checks every report against the oldest expected one.
// Both sides idle in random bursts outside the last phase; the register
// settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_gshare_branch_predictor_btb;
    import gbp_pkg::*;

    localparam int PAT_BITS    = PATTERN_INDEX_BITS_DEF;
    localparam int PAT_ENTRIES = 1 << PAT_BITS;
    localparam int BTB_BITS    = $clog2(BTB_DEPTH_DEF);
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 215;
    localparam int SPARE_ITEMS = 60;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_AFTER  = 500;
    localparam int HOLD_CYCLES = 80;

    // register indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_3 = 2'd3;

    // register settings per phase, phase 0 in the low nibble
    localparam logic [NUM_PHASES*4-1:0] HIST_PLAN =
        {4'd4, 4'd2, 4'd7, 4'd11, 4'd1, 4'd10, 4'd15, 4'd0};
    localparam logic [NUM_PHASES*4-1:0] BTB_PLAN =
        {4'd1, 4'd4, 4'd7, 4'd2, 4'd3, 4'd6, 4'hF, 4'd0};

    logic               i_clk     = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    t_in_item           in_data   = '0;
    logic               out_stall = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out_data;

    gshare_branch_predictor_btb u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predictor state mirrored by the bench
    logic [1:0]  pht_copy [PAT_ENTRIES];
    logic [63:0] btb_copy [BTB_DEPTH_DEF];
    logic [HIST_MAX_BITS-1:0] ghist_copy;
    logic [31:0] branch_total, direction_total, target_total;
    logic [3:0]  hist_bits_cfg;
    logic [2:0]  btb_bits_cfg;

    // stimulus and scoreboard bookkeeping
    t_in_item    pending_branches [$];
    t_out_item   expected_reports [$];
    t_out_item   report_want;
    int          branches_queued   = 0;
    int          branches_accepted = 0;
    int          reports_checked   = 0;
    int          error_count       = 0;
    int          cycle_count       = 0;
    int          send_gap          = 0;
    int          stall_left        = 0;
    int          long_hold_left    = 0;
    bit          long_hold_done    = 0;
    bit          quiet             = 0;

    // hot branches of the current phase: a small loop-like working set
    logic [63:0] hot_pc     [8];
    logic [63:0] hot_target [8];
    int          hot_bias   [8];

    // compute the report for one branch and update the mirrored state
    function automatic t_out_item predict_branch(input t_in_item br);
        t_out_item   rep;
        logic [63:0] word, fall, btb_mask, btb_sel, guess;
        logic [10:0] hist_span;
        logic [HIST_MAX_BITS-1:0] hist_mask;
        logic [PAT_BITS-1:0] pat_idx;
        logic [BTB_BITS-1:0] btb_idx;
        logic        guess_taken, dir_ok, tgt_ok;
        int          hist_len;
        word      = br.branch_pc >> 2;
        hist_len  = (hist_bits_cfg > HIST_MAX_BITS) ? HIST_MAX_BITS : int'(hist_bits_cfg);
        hist_span = (11'd1 << hist_len) - 11'd1;
        hist_mask = hist_span[HIST_MAX_BITS-1:0];
        pat_idx   = word[PAT_BITS-1:0] ^ (ghist_copy & hist_mask);
        btb_mask  = (64'd1 << btb_bits_cfg) - 64'd1;
        btb_sel   = word & btb_mask;
        btb_idx   = btb_sel[BTB_BITS-1:0];

        guess_taken = pht_copy[pat_idx] >= 2'd2;
        fall        = br.branch_pc + INSN_BYTES;
        guess       = guess_taken ? btb_copy[btb_idx] : fall;
        dir_ok      = guess_taken == br.taken;
        tgt_ok      = br.taken ? (guess == br.actual_target) : (guess == fall);

        // saturating running totals
        if (branch_total != '1) branch_total++;
        if (dir_ok && direction_total != '1) direction_total++;
        if (tgt_ok && target_total != '1) target_total++;

        // counter, buffer and history update
        if (br.taken) begin
            btb_copy[btb_idx] = br.actual_target;
            if (pht_copy[pat_idx] != CNT_STRONG_TAKEN) pht_copy[pat_idx]++;
        end else if (pht_copy[pat_idx] != CNT_STRONG_NOT_TAKEN) begin
            pht_copy[pat_idx]--;
        end
        ghist_copy = {ghist_copy[HIST_MAX_BITS-2:0], br.taken} & hist_mask;

        rep.predicted_taken   = guess_taken;
        rep.predicted_target  = guess;
        rep.direction_correct = dir_ok;
        rep.target_correct    = tgt_ok;
        rep.branch_count      = branch_total;
        rep.direction_hits    = direction_total;
        rep.target_hits       = target_total;
        return rep;
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom(), $urandom()};
    endfunction

    // mostly hot loop branches, then low-address aliasing, then pure noise
    function automatic t_in_item random_branch();
        t_in_item br;
        int       pick, k;
        pick = $urandom_range(99);
        if (pick < 65) begin
            k = $urandom_range(7);
            br.branch_pc     = hot_pc[k];
            br.taken         = $urandom_range(99) < hot_bias[k];
            br.actual_target = ($urandom_range(9) == 0) ? random_word() : hot_target[k];
        end else if (pick < 85) begin
            br.branch_pc     = {32'd0, $urandom_range(32'hFFFF, 0)};
            br.taken         = 1'($urandom_range(1));
            br.actual_target = ($urandom_range(3) == 0) ? br.branch_pc + INSN_BYTES
                                                        : {32'd0, $urandom_range(32'hFFFF, 0)};
        end else begin
            br.branch_pc     = random_word();
            br.taken         = 1'($urandom_range(1));
            br.actual_target = random_word();
        end
        return br;
    endfunction

    task automatic pick_hot_branches();
        int biases [5] = '{0, 5, 50, 95, 100};
        for (int k = 0; k < 8; k++) begin
            hot_pc[k]     = ($urandom_range(3) == 0) ? random_word()
                                                     : {32'd0, $urandom_range(32'hFFFF, 0)};
            hot_pc[k]     = hot_pc[k] & ~64'd3;
            hot_target[k] = ($urandom_range(1) == 0) ? random_word()
                                                     : {32'd0, $urandom_range(32'hFFFF, 0)};
            hot_bias[k]   = biases[$urandom_range(4)];
        end
    endtask

    task automatic queue_branch(input logic [63:0] pc, input logic tk, input logic [63:0] tgt);
        t_in_item br;
        br.branch_pc     = pc;
        br.taken         = tk;
        br.actual_target = tgt;
        pending_branches = {pending_branches, br};
        branches_queued++;
    endtask

    // wait until every queued branch has been accepted and reported
    task automatic wait_for_idle();
        do @(negedge i_clk);
        while (branches_accepted != branches_queued || expected_reports.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    // one register write, mirrored at the edge that takes it
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_HISTORY_BITS) begin
            hist_bits_cfg = val;
        end else if (idx == CFG_BTB_INDEX_BITS) begin
            btb_bits_cfg = val[2:0];
        end
    endtask

    // branch driver
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_reports = {expected_reports, predict_branch(in_data)};
                branches_accepted++;
            end
            if (!in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_branches.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(99) < 8) begin
                    send_gap = $urandom_range(10, 1) - 1;
                    in_valid <= 1'b0;
                end else begin
                    in_data  <= pending_branches.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // report monitor and receiver stall
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                reports_checked++;
                if (expected_reports.size() == 0) begin
                    $error("report with no branch pending");
                    error_count++;
                end else begin
                    report_want = expected_reports.pop_front();
                    if (o_out_data.predicted_taken !== report_want.predicted_taken) begin
                        $error("predicted_taken: expected %0d, got %0d",
                               report_want.predicted_taken, o_out_data.predicted_taken);
                        error_count++;
                    end
                    if (o_out_data.predicted_target !== report_want.predicted_target) begin
                        $error("predicted_target: expected %h, got %h",
                               report_want.predicted_target, o_out_data.predicted_target);
                        error_count++;
                    end
                    if (o_out_data.direction_correct !== report_want.direction_correct) begin
                        $error("direction_correct: expected %0d, got %0d",
                               report_want.direction_correct, o_out_data.direction_correct);
                        error_count++;
                    end
                    if (o_out_data.target_correct !== report_want.target_correct) begin
                        $error("target_correct: expected %0d, got %0d",
                               report_want.target_correct, o_out_data.target_correct);
                        error_count++;
                    end
                    if (o_out_data.branch_count !== report_want.branch_count) begin
                        $error("branch_count: expected %0d, got %0d",
                               report_want.branch_count, o_out_data.branch_count);
                        error_count++;
                    end
                    if (o_out_data.direction_hits !== report_want.direction_hits) begin
                        $error("direction_hits: expected %0d, got %0d",
                               report_want.direction_hits, o_out_data.direction_hits);
                        error_count++;
                    end
                    if (o_out_data.target_hits !== report_want.target_hits) begin
                        $error("target_hits: expected %0d, got %0d",
                               report_want.target_hits, o_out_data.target_hits);
                        error_count++;
                    end
                end
            end
            // one long hold-off to back the block up, then random bursts
            if (long_hold_left > 0) begin
                long_hold_left--;
                out_stall <= 1'b1;
            end else if (!long_hold_done && reports_checked >= HOLD_AFTER) begin
                long_hold_done = 1;
                long_hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(99) < 10) begin
                stall_left = $urandom_range(10, 1) - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("gshare_branch_predictor_btb test failed");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        for (int i = 0; i < PAT_ENTRIES; i++) pht_copy[i] = CNT_STRONG_TAKEN;
        for (int i = 0; i < BTB_DEPTH_DEF; i++) btb_copy[i] = '0;
        ghist_copy      = '0;
        branch_total    = '0;
        direction_total = '0;
        target_total    = '0;
        hist_bits_cfg   = HISTORY_BITS_RESET;
        btb_bits_cfg    = BTB_INDEX_BITS_RESET;

        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: address extremes, fall-through wrap, same entry back to back
        queue_branch(64'd0, 1'b1, 64'd0);
        queue_branch(64'd0, 1'b0, '1);
        queue_branch('1, 1'b0, 64'd0);
        queue_branch('1, 1'b1, '1);
        queue_branch('1, 1'b1, '1);
        queue_branch(64'hFFFF_FFFF_FFFF_FFFC, 1'b0, 64'd0);
        queue_branch(64'd8, 1'b1, 64'hC);
        // one branch address not taken, then taken; the changing history moves it between counters
        repeat (5) queue_branch(64'h1000, 1'b0, 64'h2000);
        repeat (5) queue_branch(64'h1000, 1'b1, 64'h2000);
        // alternating bit patterns
        queue_branch(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'h5555_5555_5555_5555);
        queue_branch(64'h5555_5555_5555_5555, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_branch(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h5555_5555_5555_5555);
        queue_branch(64'h5555_5555_5555_5555, 1'b1, 64'h1234_5678_9ABC_DEF0);
        wait_for_idle();

        // writes to unmapped indexes must leave the settings alone
        write_register(CFG_UNMAPPED_2, 4'hF);
        write_register(CFG_UNMAPPED_3, 4'h0);
        @(negedge i_clk);
        pick_hot_branches();
        repeat (SPARE_ITEMS) begin
            pending_branches = {pending_branches, random_branch()};
            branches_queued++;
        end

        // random phases, history carried across width changes
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_for_idle();
            write_register(CFG_HISTORY_BITS, HIST_PLAN[ph*4 +: 4]);
            write_register(CFG_BTB_INDEX_BITS, BTB_PLAN[ph*4 +: 4]);
            @(negedge i_clk);
            quiet = (ph == NUM_PHASES - 1);
            pick_hot_branches();
            repeat (PHASE_ITEMS) begin
                pending_branches = {pending_branches, random_branch()};
                branches_queued++;
            end
        end

        wait_for_idle();
        repeat (5) @(posedge i_clk);
        if (error_count == 0) begin
            $display("gshare_branch_predictor_btb test passed");
        end else begin
            $display("gshare_branch_predictor_btb test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/gbp_pkg.sv
design/gbp_ram.sv
design/gshare_branch_predictor_btb.sv
tb/tb_gshare_branch_predictor_btb.sv
